>>> hw/rtl/dht_pkg.sv
// Shared types, codes and constants for the double hashing table.
package dht_pkg;

  // Field widths.
  localparam int KEY_W  = 64;
  localparam int LEN_W  = 4;
  localparam int VAL_W  = 9;
  localparam int SIZE_W = 9;
  localparam int SLOT_W = 8;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 32;
  localparam int CMD_W  = 2;

  // Parameter defaults.
  localparam int DEF_TABLE_DEPTH   = 256;
  localparam int DEF_MAX_KEY_CHARS = 8;

  // Register reset values.
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(256);

  // Hash constants.
  localparam logic [CNT_W-1:0] XOR_SEED  = 32'd11;
  localparam logic [CNT_W-1:0] CHAR_BIAS = 32'd96;  // 'a' minus one

  // Commands.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_WALK_STOP = 3'd4;

  // Configuration register indexes.
  localparam logic REG_TABLE_SIZE   = 1'b0;
  localparam logic REG_PRIMARY_HASH = 1'b1;

  // One table slot as stored in memory.
  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

>>> hw/rtl/dht_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/double_hashing_table.sv
// Open-addressed key table with double hashing over keys of up to eight characters.
// After reset the block clears the used flags of min(TABLE_DEPTH, 512) slots, one slot
// per cycle, and stalls its input until that pass is done. An item is then taken in
// and hashed on one shared remainder unit that retires four dividend bits per cycle
// (per key character a step hash reduction, plus an xor-shift reduction when the
// xor-shift home hash is chosen over the polynomial one; then the final home and step
// reductions). It is then probed slot by slot, each probe a registered slot memory
// read and then a check, a delete probing its sequence twice, and the result is
// handed over last. One item is in work at a time.
module double_hashing_table
  import dht_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_KEY_CHARS = DEF_MAX_KEY_CHARS
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [KEY_W-1:0]  in_key_chars,
  input  logic [LEN_W-1:0]  in_key_length,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [VAL_W-1:0]  out_found_value,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [SIZE_W-1:0] out_occupancy,
  output logic [CNT_W-1:0]  out_collisions_seen,
  output logic [CNT_W-1:0]  out_probes_seen
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CLR_N = (TABLE_DEPTH < 512) ? TABLE_DEPTH : 512;
  localparam int CLR_W = 10;
  localparam int SW    = $bits(slot_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHAR, S_DIV, S_PRD, S_PCK, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_INS, PH_SRCH, PH_WALK} phase_t;

  typedef enum logic [1:0] {D_STEP_CHAR, D_XOR_CHAR, D_HOME, D_STEP_FIN} div_op_t;

  // Registers.
  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  div_op_t             dop_r, dop_nxt;
  logic [SIZE_W-1:0]   tsize_r, tsize_nxt;
  logic                prim_r, prim_nxt;
  logic [CLR_W-1:0]    clr_r, clr_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SIZE_W-1:0]   m_r, m_nxt;
  logic [LEN_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    ph_r, ph_nxt;
  logic [CNT_W-1:0]    xh_r, xh_nxt;
  logic [SIZE_W-1:0]   sh_r, sh_nxt;
  logic [SIZE_W-1:0]   home_r, home_nxt;
  logic [SIZE_W-1:0]   step_r, step_nxt;
  logic [SIZE_W-1:0]   pos_r, pos_nxt;
  logic [SIZE_W-1:0]   inc_r, inc_nxt;
  logic [SIZE_W-1:0]   pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]    dq_r, dq_nxt;
  logic [SIZE_W-1:0]   drem_r, drem_nxt;
  logic [2:0]          dcnt_r, dcnt_nxt;
  logic                dneg_r, dneg_nxt;
  logic [SIZE_W-1:0]   ent_r, ent_nxt;
  logic [CNT_W-1:0]    coll_r, coll_nxt;
  logic [CNT_W-1:0]    prb_r, prb_nxt;
  logic                full_r, full_nxt;
  logic [STAT_W-1:0]   rstat_r, rstat_nxt;
  logic [VAL_W-1:0]    rval_r, rval_nxt;
  logic [SLOT_W-1:0]   rslot_r, rslot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [SIZE_W-1:0]   out_occ_r, out_occ_nxt;
  logic [CNT_W-1:0]    out_coll_r, out_coll_nxt;
  logic [CNT_W-1:0]    out_prb_r, out_prb_nxt;

  // Combinational helpers.
  logic                in_acc;
  logic [LEN_W-1:0]    len_sat;
  logic [KEY_W-1:0]    key_mask;
  logic [SIZE_W-1:0]   m_calc;
  logic [7:0]          cur_char;
  logic [CNT_W-1:0]    xor_val;
  logic [SIZE_W:0]     rem_w;
  logic [CNT_W-1:0]    q_w;
  logic [SIZE_W-1:0]   r_fin;
  logic [SIZE_W-1:0]   r_floor;
  logic [CNT_W-1:0]    r_trunc;
  logic                dv_go;
  logic [CNT_W-1:0]    dv_val;
  logic                dv_sgn;
  div_op_t             dv_op;
  logic [SIZE_W:0]     psum, isum;
  logic [SIZE_W-1:0]   pos_adv, inc_adv;
  logic                last_probe;
  logic                slot_hit;
  logic                out_free;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  slot_t               mem_wdata;
  slot_t               mem_rdata;

  // Slot memory.
  dht_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (AW'(pos_r)),
    .rdata (mem_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Key length saturation and masking of bytes past the length.
  always_comb begin
    len_sat = (in_key_length > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS)
                                                       : in_key_length;
    for (int b = 0; b < 8; b++) begin
      key_mask[8*b +: 8] = (LEN_W'(b) < len_sat) ? in_key_chars[8*b +: 8] : 8'd0;
    end
  end

  // Effective modulus from the table size register.
  always_comb begin
    if (tsize_r == '0) begin
      m_calc = SIZE_W'(1);
    end else if (int'(tsize_r) > TABLE_DEPTH) begin
      m_calc = SIZE_W'(TABLE_DEPTH);
    end else begin
      m_calc = tsize_r;
    end
  end

  // Current key character and the xor-shift mix of it.
  assign cur_char = key_r[8*k_r[2:0] +: 8];
  assign xor_val  = xh_r ^ (32'(cur_char) - CHAR_BIAS + (xh_r << 5)
                            + 32'($signed(xh_r) >>> 2));

  // Shared remainder unit: four restoring steps per cycle.
  always_comb begin
    rem_w = {1'b0, drem_r};
    q_w   = dq_r;
    for (int j = 0; j < 4; j++) begin
      rem_w = {rem_w[SIZE_W-1:0], q_w[CNT_W-1]};
      q_w   = q_w << 1;
      if (rem_w >= {1'b0, m_r}) begin
        rem_w = rem_w - {1'b0, m_r};
      end
    end
    r_fin   = rem_w[SIZE_W-1:0];
    r_floor = (dneg_r && r_fin != '0) ? (m_r - r_fin) : r_fin;
    r_trunc = dneg_r ? (32'd0 - 32'(r_fin)) : 32'(r_fin);
  end

  // Probe sequence advance: pos += i*step and the next i*step, both mod M.
  always_comb begin
    psum    = {1'b0, pos_r} + {1'b0, inc_r};
    pos_adv = (psum >= {1'b0, m_r}) ? SIZE_W'(psum - {1'b0, m_r}) : psum[SIZE_W-1:0];
    isum    = {1'b0, inc_r} + {1'b0, step_r};
    inc_adv = (isum >= {1'b0, m_r}) ? SIZE_W'(isum - {1'b0, m_r}) : isum[SIZE_W-1:0];
  end

  assign last_probe = (pcnt_r == m_r - SIZE_W'(1));
  assign slot_hit   = mem_rdata.used && (mem_rdata.len == len_r) && (mem_rdata.key == key_r);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    dop_nxt        = dop_r;
    tsize_nxt      = tsize_r;
    prim_nxt       = prim_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    m_nxt          = m_r;
    k_nxt          = k_r;
    ph_nxt         = ph_r;
    xh_nxt         = xh_r;
    sh_nxt         = sh_r;
    home_nxt       = home_r;
    step_nxt       = step_r;
    pos_nxt        = pos_r;
    inc_nxt        = inc_r;
    pcnt_nxt       = pcnt_r;
    dq_nxt         = dq_r;
    drem_nxt       = drem_r;
    dcnt_nxt       = dcnt_r;
    dneg_nxt       = dneg_r;
    ent_nxt        = ent_r;
    coll_nxt       = coll_r;
    prb_nxt        = prb_r;
    full_nxt       = full_r;
    rstat_nxt      = rstat_r;
    rval_nxt       = rval_r;
    rslot_nxt      = rslot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_slot_nxt   = out_slot_r;
    out_occ_nxt    = out_occ_r;
    out_coll_nxt   = out_coll_r;
    out_prb_nxt    = out_prb_r;
    dv_go          = 1'b0;
    dv_val         = '0;
    dv_sgn         = 1'b0;
    dv_op          = D_HOME;
    mem_we         = 1'b0;
    mem_waddr      = AW'(pos_r);
    mem_wdata      = '0;

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_SIZE:   tsize_nxt = cfg_data;
        REG_PRIMARY_HASH: prim_nxt  = cfg_data[0];
      endcase
    end

    // A taken result frees the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(clr_r);
        clr_nxt   = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          key_nxt   = key_mask;
          len_nxt   = len_sat;
          m_nxt     = m_calc;
          k_nxt     = '0;
          ph_nxt    = '0;
          xh_nxt    = XOR_SEED;
          sh_nxt    = SIZE_W'(1);
          state_nxt = S_CHAR;
        end
      end

      S_CHAR: begin
        if (k_r == len_r) begin
          // Home slot: floor remainder of the signed primary hash.
          dv_go  = 1'b1;
          dv_val = prim_r ? xh_r : ph_r;
          dv_sgn = 1'b1;
          dv_op  = D_HOME;
        end else begin
          ph_nxt = (ph_r << 5) + (ph_r << 2) + ph_r + 32'(cur_char);
          dv_go  = 1'b1;
          dv_val = (32'(sh_r) << 5) + (32'(sh_r) << 2) + 32'(sh_r) + 32'(cur_char);
          dv_op  = D_STEP_CHAR;
        end
      end

      S_DIV: begin
        dq_nxt   = q_w;
        drem_nxt = r_fin;
        dcnt_nxt = dcnt_r + 3'd1;
        if (dcnt_r == 3'd7) begin
          unique case (dop_r)
            D_STEP_CHAR: begin
              sh_nxt = r_fin;
              if (prim_r) begin
                dv_go  = 1'b1;
                dv_val = xor_val;
                dv_sgn = 1'b1;
                dv_op  = D_XOR_CHAR;
              end else begin
                k_nxt     = k_r + LEN_W'(1);
                state_nxt = S_CHAR;
              end
            end
            D_XOR_CHAR: begin
              xh_nxt    = r_trunc;
              k_nxt     = k_r + LEN_W'(1);
              state_nxt = S_CHAR;
            end
            D_HOME: begin
              home_nxt = r_floor;
              dv_go    = 1'b1;
              dv_val   = (32'(sh_r) << 3) + (32'(sh_r) << 1) + 32'd1;
              dv_op    = D_STEP_FIN;
            end
            D_STEP_FIN: begin
              step_nxt  = r_fin;
              pos_nxt   = home_r;
              inc_nxt   = r_fin;
              pcnt_nxt  = '0;
              rstat_nxt = STAT_DONE;
              rval_nxt  = '0;
              rslot_nxt = '0;
              priority case (cmd_r)
                CMD_INSERT: begin
                  if (full_r) begin
                    rstat_nxt = STAT_IGNORED;
                    state_nxt = S_DONE;
                  end else begin
                    phase_nxt = PH_INS;
                    state_nxt = S_PRD;
                  end
                end
                CMD_SEARCH, CMD_DELETE: begin
                  phase_nxt = PH_SRCH;
                  state_nxt = S_PRD;
                end
                default: begin
                  state_nxt = S_DONE;
                end
              endcase
            end
          endcase
        end
      end

      S_PRD: begin
        state_nxt = S_PCK;
      end

      S_PCK: begin
        state_nxt = S_PRD;
        pos_nxt   = pos_adv;
        inc_nxt   = inc_adv;
        pcnt_nxt  = pcnt_r + SIZE_W'(1);
        unique case (phase_r)
          PH_INS: begin
            if (!mem_rdata.used) begin
              mem_we          = 1'b1;
              mem_wdata.used  = 1'b1;
              mem_wdata.len   = len_r;
              mem_wdata.key   = key_r;
              mem_wdata.value = ent_r + VAL_W'(1);
              rval_nxt        = ent_r + VAL_W'(1);
              ent_nxt         = ent_r + SIZE_W'(1);
              rslot_nxt       = pos_r[SLOT_W-1:0];
              state_nxt       = S_DONE;
            end else begin
              coll_nxt = (coll_r == '1) ? coll_r : coll_r + CNT_W'(1);
              if (last_probe) begin
                full_nxt  = 1'b1;
                rstat_nxt = STAT_FULL;
                state_nxt = S_DONE;
              end
            end
          end
          PH_SRCH: begin
            if (slot_hit) begin
              if (cmd_r == CMD_SEARCH) begin
                rval_nxt  = mem_rdata.value;
                rslot_nxt = pos_r[SLOT_W-1:0];
                state_nxt = S_DONE;
              end else begin
                // Delete: walk the used slots from home again.
                phase_nxt = PH_WALK;
                pos_nxt   = home_r;
                inc_nxt   = step_r;
                pcnt_nxt  = '0;
              end
            end else begin
              prb_nxt = (prb_r == '1) ? prb_r : prb_r + CNT_W'(1);
              if (last_probe) begin
                rstat_nxt = STAT_NOT_FOUND;
                state_nxt = S_DONE;
              end
            end
          end
          PH_WALK: begin
            if (!mem_rdata.used) begin
              rstat_nxt = STAT_WALK_STOP;
              state_nxt = S_DONE;
            end else if (slot_hit) begin
              mem_we    = 1'b1;
              ent_nxt   = (ent_r != '0) ? ent_r - SIZE_W'(1) : ent_r;
              rslot_nxt = pos_r[SLOT_W-1:0];
              state_nxt = S_DONE;
            end else if (last_probe) begin
              rstat_nxt = STAT_WALK_STOP;
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rstat_r;
          out_value_nxt  = rval_r;
          out_slot_nxt   = rslot_r;
          out_occ_nxt    = ent_r;
          out_coll_nxt   = coll_r;
          out_prb_nxt    = prb_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Launch of a reduction on the shared remainder unit.
    if (dv_go) begin
      dneg_nxt  = dv_sgn && dv_val[CNT_W-1];
      dq_nxt    = (dv_sgn && dv_val[CNT_W-1]) ? (32'd0 - dv_val) : dv_val;
      drem_nxt  = '0;
      dcnt_nxt  = '0;
      dop_nxt   = dv_op;
      state_nxt = S_DIV;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      tsize_r     <= TABLE_SIZE_RST;
      prim_r      <= 1'b0;
      ent_r       <= '0;
      coll_r      <= '0;
      prb_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tsize_r     <= tsize_nxt;
      prim_r      <= prim_nxt;
      ent_r       <= ent_nxt;
      coll_r      <= coll_nxt;
      prb_r       <= prb_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r      <= phase_nxt;
    dop_r        <= dop_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    m_r          <= m_nxt;
    k_r          <= k_nxt;
    ph_r         <= ph_nxt;
    xh_r         <= xh_nxt;
    sh_r         <= sh_nxt;
    home_r       <= home_nxt;
    step_r       <= step_nxt;
    pos_r        <= pos_nxt;
    inc_r        <= inc_nxt;
    pcnt_r       <= pcnt_nxt;
    dq_r         <= dq_nxt;
    drem_r       <= drem_nxt;
    dcnt_r       <= dcnt_nxt;
    dneg_r       <= dneg_nxt;
    rstat_r      <= rstat_nxt;
    rval_r       <= rval_nxt;
    rslot_r      <= rslot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
    out_occ_r    <= out_occ_nxt;
    out_coll_r   <= out_coll_nxt;
    out_prb_r    <= out_prb_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found_value     = out_value_r;
  assign out_slot_index      = out_slot_r;
  assign out_occupancy       = out_occ_r;
  assign out_collisions_seen = out_coll_r;
  assign out_probes_seen     = out_prb_r;

  // The partial remainder stays reduced below the modulus.
  a_rem_below_m: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (drem_r < m_r))
    else $error("remainder unit left its range");

  // Probe position and increment stay inside the table.
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRD || state_r == S_PCK) |-> (pos_r < m_r && inc_r < m_r))
    else $error("probe position outside the table");

  // The full flag is only set by an insert that ran out of probes.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> $past(state_r == S_PCK && phase_r == PH_INS && mem_rdata.used))
    else $error("full flag set without a failed insert");

  // The collision total never goes down.
  a_coll_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (coll_r >= $past(coll_r)))
    else $error("collision total decreased");

endmodule
